// ===== rtl/grid_min_path_sum_macros.svh =====
// ----------------------------------------------------------------------------
// grid_min_path_sum_macros
// assertion macros shared by the grid path sum design
// ----------------------------------------------------------------------------
`ifndef GRID_MIN_PATH_SUM_MACROS_SVH
`define GRID_MIN_PATH_SUM_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define GMPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmps assertion failed");
// next-cycle implication, checked outside reset
`define GMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmps assertion failed");
`else
`define GMPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define GMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gmps_pkg.sv =====
// ----------------------------------------------------------------------------
// gmps_pkg
// constants and types of the grid minimum path sum block
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_COLS  = 256;
    localparam int COST_BITS = 16;
    localparam int COST_W    = 16;   // width of the cell_cost field
    localparam int SUM_BITS  = 25;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_LIMIT = 256;
    localparam int IDX_W     = 8;    // holds positions 0..DIM_LIMIT-1
    localparam int COL_HI    = (MAX_COLS < DIM_LIMIT) ? MAX_COLS : DIM_LIMIT;
    localparam int ADDR_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef logic [SUM_BITS-1:0] t_sum;

    localparam t_sum UNREACH = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic first;     // top-left cell of the grid
        logic has_up;    // a row above exists
        logic has_left;  // a column to the left exists
        logic grid_end;  // bottom-right cell, produces a result
    } t_cell_ctl;

endpackage

// ===== rtl/gmps_in_if.sv =====
// ----------------------------------------------------------------------------
// gmps_in_if
// cell channel: one grid cell per beat in raster order
// ----------------------------------------------------------------------------
interface gmps_in_if
    import gmps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] cell_cost;
    logic              blocked;

    modport source (output valid, cell_cost, blocked, input ready);
    modport sink   (input valid, cell_cost, blocked, output ready);
endinterface

// ===== rtl/gmps_out_if.sv =====
// ----------------------------------------------------------------------------
// gmps_out_if
// result channel: one beat per completed grid
// ----------------------------------------------------------------------------
interface gmps_out_if
    import gmps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] path_sum;
    logic                no_path;

    modport source (output valid, path_sum, no_path, input ready);
    modport sink   (input valid, path_sum, no_path, output ready);
endinterface

// ===== rtl/gmps_cell.sv =====
// ----------------------------------------------------------------------------
// gmps_cell
// best cost into one cell: min of up and left, saturating add of the cost
// ----------------------------------------------------------------------------
module gmps_cell
    import gmps_pkg::*;
(
    input  t_cell_ctl            i_ctl,
    input  logic                 i_blocked,
    input  logic [COST_BITS-1:0] i_cost,
    input  t_sum                 i_up,
    input  t_sum                 i_left,
    output t_sum                 o_cost
);

    t_sum              up;
    t_sum              left;
    t_sum              best;
    logic [SUM_BITS:0] sum;

    always_comb begin
        up   = i_ctl.has_up   ? i_up   : UNREACH;
        left = i_ctl.has_left ? i_left : UNREACH;
        if (i_ctl.first) begin
            best = '0;
        end else begin
            best = (up < left) ? up : left;
        end
        sum = {1'b0, best} + (SUM_BITS + 1)'(i_cost);

        if (i_blocked || best == UNREACH) begin
            o_cost = UNREACH;
        end else if (sum >= {1'b0, UNREACH}) begin
            // a real sum never reads as unreachable
            o_cost = UNREACH - t_sum'(1);
        end else begin
            o_cost = sum[SUM_BITS-1:0];
        end
    end

endmodule

// ===== rtl/grid_min_path_sum.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum
// least down/right path cost through a grid of cells with obstacles
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  i_cell    in   cell_cost, blocked (one grid cell, raster order)
//  o_res     out  path_sum, no_path (one beat per grid, after its last cell)
//  i_cfg_*   in   write enable, register index, 9-bit data (num_rows, num_cols)
//
//  one cell per cycle unless a grid result stalls on o_res; the loop is the row buffer read, min, add and write
//  the last cell of a grid passes the first-stage registers, then the result register, before its result shows on o_res
//  the row buffer is read as a cell enters the first stage, with a bypass from the cell in flight
//  reset clears counters and valids and sets the configuration to 1x1; the row buffer is not cleared
//  a stalled result holds i_cell only when the cell in the first stage also ends a grid
// ----------------------------------------------------------------------------
`include "grid_min_path_sum_macros.svh"

module grid_min_path_sum
    import gmps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gmps_in_if.sink              i_cell,
    gmps_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]     r_num_rows;
    logic [CFG_W-1:0]     r_num_cols;
    logic [IDX_W-1:0]     r_col;
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     n_col;
    logic [IDX_W-1:0]     n_row;

    logic                 r_s1_valid;
    t_cell_ctl            r_s1_ctl;
    t_cell_ctl            n_ctl;
    logic [COST_BITS-1:0] r_s1_cost;
    logic                 r_s1_blk;
    logic [IDX_W-1:0]     r_s1_col;
    t_sum                 r_up;
    t_sum                 r_left;

    logic                 r_out_valid;
    t_sum                 r_out_sum;
    logic                 r_out_nopath;

    t_sum                 mem [MAX_COLS];

    logic [CFG_W-1:0]     rows_c;
    logic [CFG_W-1:0]     cols_c;
    logic                 row_end;
    logic                 grid_end;
    logic                 advance;
    logic                 in_fire;
    logic                 s1_fire;
    t_sum                 w_cur;

    // register values clamped to the usable range
    always_comb begin
        if (r_num_rows == '0) begin
            rows_c = CFG_W'(1);
        end else if (r_num_rows > CFG_W'(DIM_LIMIT)) begin
            rows_c = CFG_W'(DIM_LIMIT);
        end else begin
            rows_c = r_num_rows;
        end
        if (r_num_cols == '0) begin
            cols_c = CFG_W'(1);
        end else if (r_num_cols > CFG_W'(COL_HI)) begin
            cols_c = CFG_W'(COL_HI);
        end else begin
            cols_c = r_num_cols;
        end
    end

    assign advance = !r_s1_valid || !r_s1_ctl.grid_end || !r_out_valid || o_res.ready;
    assign in_fire = i_cell.valid && advance;
    assign s1_fire = r_s1_valid && advance;
    assign i_cell.ready = advance;

    always_comb begin
        row_end  = (CFG_W'(r_col) + CFG_W'(1)) >= cols_c;
        grid_end = row_end && ((CFG_W'(r_row) + CFG_W'(1)) >= rows_c);

        n_ctl.first    = (r_row == '0) && (r_col == '0);
        n_ctl.has_up   = (r_row != '0);
        n_ctl.has_left = (r_col != '0);
        n_ctl.grid_end = grid_end;

        if (grid_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + IDX_W'(1);
        end else begin
            n_col = r_col + IDX_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_W'(1);
            r_num_cols <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                REG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position and first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (advance) begin
                r_s1_valid <= in_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctl  <= n_ctl;
            r_s1_cost <= i_cell.cell_cost[COST_BITS-1:0];
            r_s1_blk  <= i_cell.blocked;
            r_s1_col  <= r_col;
        end
    end

    // row buffer: write behind, read ahead, bypass when both hit one column
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            mem[ADDR_W'(r_s1_col)] <= w_cur;
        end
        if (in_fire) begin
            if (s1_fire && r_s1_col == r_col) begin
                r_up <= w_cur;
            end else begin
                r_up <= mem[ADDR_W'(r_col)];
            end
        end
    end

    gmps_cell u_cell (
        .i_ctl     (r_s1_ctl),
        .i_blocked (r_s1_blk),
        .i_cost    (r_s1_cost),
        .i_up      (r_up),
        .i_left    (r_left),
        .o_cost    (w_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= UNREACH;
        end else if (s1_fire) begin
            r_left <= w_cur;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_ctl.grid_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_ctl.grid_end) begin
            r_out_nopath <= (w_cur == UNREACH);
            r_out_sum    <= (w_cur == UNREACH) ? '0 : w_cur;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.path_sum = r_out_sum;
    assign o_res.no_path  = r_out_nopath;

    `GMPS_ASSERT_NOW(a_result_from_grid_end, i_clk, i_rst_n, $rose(r_out_valid), $past(s1_fire && r_s1_ctl.grid_end))
    `GMPS_ASSERT_NOW(a_stall_only_on_full_out, i_clk, i_rst_n, !i_cell.ready, r_s1_valid && r_s1_ctl.grid_end && r_out_valid && !o_res.ready)
    `GMPS_ASSERT_NEXT(a_grid_end_rewinds, i_clk, i_rst_n, in_fire && grid_end, r_col == '0 && r_row == '0)

endmodule

// ===== bench/grid_min_path_sum_test.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum_test
// self-checking bench for the grid minimum path sum block
// ----------------------------------------------------------------------------
//  a table of hand-picked cells runs first: 1x1 grids at the cost extremes,
//  clamped dimensions, a small grid with an obstacle, and blocked start and
//  end cells. Random grids follow, mostly small, with a few at the largest
//  row and column counts and with random obstacle density. Every accepted
//  cell goes through a local copy of the forward pass, and each result beat
//  is compared with the oldest pending grid result. Both channels idle in
//  random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module grid_min_path_sum_test;
    import gmps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_CELLS = 1400;
    localparam int QUIET_AFTER  = 1200;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT [3]  = '{0, 10, 35};
    localparam int BLOCK_PCT [4] = '{0, 8, 25, 50};

    typedef struct packed {
        t_sum sum;
        logic no_path;
    } t_result;

    typedef struct packed {
        logic              set_dims;
        logic [CFG_W-1:0]  rows_raw;
        logic [CFG_W-1:0]  cols_raw;
        logic [COST_W-1:0] cost;
        logic              blocked;
        logic              typed;
        t_result           want;
    } t_dir_row;

    localparam t_result NONE    = '{'0, 1'b0};
    localparam t_result NO_PATH = '{'0, 1'b1};

    // 1x1 grids under the reset dimensions first, then clamping and small grids
    localparam t_dir_row DIRECTED_CELLS [25] = '{
        '{1'b0, 9'd1, 9'd1, 16'd0,     1'b0, 1'b1, '{25'd0, 1'b0}},
        '{1'b0, 9'd1, 9'd1, 16'hffff,  1'b0, 1'b1, '{25'd65535, 1'b0}},
        '{1'b0, 9'd1, 9'd1, 16'h5a5a,  1'b1, 1'b1, NO_PATH},
        '{1'b1, 9'd0, 9'd0, 16'ha5a5,  1'b0, 1'b1, '{25'h00a5a5, 1'b0}},
        '{1'b1, 9'd2, 9'd2, 16'hffff,  1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'hffff,  1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'hffff,  1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'hffff,  1'b0, 1'b0, NONE},
        '{1'b1, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd9,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd5,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd0,     1'b1, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd3, 9'd3, 16'd1,     1'b0, 1'b0, NONE},
        // blocked start cell
        '{1'b1, 9'd2, 9'd2, 16'd7,     1'b1, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd3,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd4,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd5,     1'b0, 1'b1, NO_PATH},
        // blocked end cell
        '{1'b0, 9'd2, 9'd2, 16'd1,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd2,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd3,     1'b0, 1'b0, NONE},
        '{1'b0, 9'd2, 9'd2, 16'd6,     1'b1, 1'b1, NO_PATH}
    };

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    gmps_in_if  cell_if ();
    gmps_out_if res_if ();

    grid_min_path_sum dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (cell_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // forward pass state of the local predictor
    t_sum             row_best [MAX_COLS];
    t_sum             left_best;
    int               at_col;
    int               at_row;
    logic [CFG_W-1:0] dim_rows_reg;
    logic [CFG_W-1:0] dim_cols_reg;

    t_result pending_sums [$];
    int      mismatches;
    int      results_seen;
    int      cells_sent;
    int      cycle_count;
    int      gap_pct;
    int      sink_pct;
    int      stall_left;
    logic    quiet;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_sum sat_add(input t_sum best, input logic [COST_W-1:0] cost);
        logic [SUM_BITS:0] s;
        if (best == UNREACH) return UNREACH;
        s = {1'b0, best} + (SUM_BITS + 1)'(cost[COST_BITS-1:0]);
        if (s >= {1'b0, UNREACH}) return UNREACH - t_sum'(1);
        return s[SUM_BITS-1:0];
    endfunction

    function automatic void walk_cell(input logic [COST_W-1:0] cost, input logic blk,
                                      output logic done, output t_result res);
        int   rows_eff;
        int   cols_eff;
        t_sum up_best;
        t_sum lf_best;
        t_sum cur;
        logic row_end;
        rows_eff = clamp_dim(dim_rows_reg, DIM_LIMIT);
        cols_eff = clamp_dim(dim_cols_reg, COL_HI);
        up_best  = (at_row > 0 && at_col < MAX_COLS) ? row_best[at_col] : UNREACH;
        lf_best  = (at_col > 0) ? left_best : UNREACH;
        if (blk) begin
            cur = UNREACH;
        end else if (at_row == 0 && at_col == 0) begin
            cur = sat_add('0, cost);
        end else begin
            cur = sat_add((up_best < lf_best) ? up_best : lf_best, cost);
        end
        if (at_col < MAX_COLS) row_best[at_col] = cur;
        left_best = cur;
        row_end = (at_col + 1 >= cols_eff);
        done    = row_end && (at_row + 1 >= rows_eff);
        res     = NONE;
        if (done) begin
            at_col    = 0;
            at_row    = 0;
            left_best = UNREACH;
            if (cur == UNREACH) res.no_path = 1'b1;
            else res.sum = cur;
        end else if (row_end) begin
            at_col    = 0;
            at_row    = at_row + 1;
            left_best = UNREACH;
        end else begin
            at_col = at_col + 1;
        end
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 3))
            0: begin
                return COST_W'($urandom_range(0, 15));
            end
            1: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                return COST_W'($urandom());
            end
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with valid possibly still high
    task automatic send_cell(input logic [COST_W-1:0] cost, input logic blk,
                             input logic typed, input t_result want);
        logic    done;
        t_result res;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            cell_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        cell_if.valid     <= 1'b1;
        cell_if.cell_cost <= cost;
        cell_if.blocked   <= blk;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        walk_cell(cost, blk, done, res);
        if (done) pending_sums.push_back(typed ? want : res);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // dimensions change only between grids, once the last result is out
    task automatic set_dims(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw);
        cell_if.valid <= 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NUM_ROWS;
        i_cfg_data <= rows_raw;
        @(negedge i_clk);
        i_cfg_idx  <= REG_NUM_COLS;
        i_cfg_data <= cols_raw;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dim_rows_reg = rows_raw;
        dim_cols_reg = cols_raw;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < sink_pct) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 15);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_sums.size() == 0) begin
                if (mismatches < 10) begin
                    $display("result beat with no grid pending: sum %0d no_path %0b",
                             res_if.path_sum, res_if.no_path);
                end
                mismatches++;
            end else begin
                exp_res = pending_sums.pop_front();
                if (res_if.path_sum !== exp_res.sum || res_if.no_path !== exp_res.no_path) begin
                    if (mismatches < 10) begin
                        $display({"mismatch at cycle %0d: expected sum %0d no_path %0b,",
                                  " got sum %0d no_path %0b"},
                                 cycle_count, exp_res.sum, exp_res.no_path,
                                 res_if.path_sum, res_if.no_path);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int               grid_no;
        int               n_cells;
        int               blk_pct;
        int               rows_eff;
        int               cols_eff;
        logic [CFG_W-1:0] rows_raw;
        logic [CFG_W-1:0] cols_raw;
        t_dir_row         row;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_NUM_ROWS;
        i_cfg_data        = '0;
        cell_if.valid     = 1'b0;
        cell_if.cell_cost = '0;
        cell_if.blocked   = 1'b0;
        res_if.ready      = 1'b0;
        stall_left        = 0;
        quiet             = 1'b0;
        gap_pct           = 20;
        sink_pct          = 20;
        mismatches        = 0;
        results_seen      = 0;
        cells_sent        = 0;
        cycle_count       = 0;
        grid_no           = 0;
        dim_rows_reg      = 9'd1;
        dim_cols_reg      = 9'd1;
        left_best         = UNREACH;
        at_col            = 0;
        at_row            = 0;
        for (int k = 0; k < MAX_COLS; k++) row_best[k] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 25; i++) begin
            row = DIRECTED_CELLS[i];
            if (row.set_dims) set_dims(row.rows_raw, row.cols_raw);
            send_cell(row.cost, row.blocked, row.typed, row.want);
        end

        cells_sent = 0;
        while (cells_sent < RANDOM_CELLS) begin
            grid_no++;
            quiet    = (cells_sent >= QUIET_AFTER);
            gap_pct  = IDLE_PCT[$urandom_range(0, 2)];
            sink_pct = IDLE_PCT[$urandom_range(0, 2)];
            if (grid_no == 4) begin
                // one full-width row, both dimensions written out of range
                rows_raw = 9'd0;
                cols_raw = 9'd511;
                blk_pct  = 0;
            end else if (grid_no == 12) begin
                rows_raw = 9'd511;
                cols_raw = 9'd1;
                blk_pct  = 0;
            end else if (grid_no == 24) begin
                rows_raw = 9'd2;
                cols_raw = 9'd256;
                blk_pct  = 1;
            end else begin
                rows_eff = $urandom_range(1, 6);
                cols_eff = $urandom_range(1, 8);
                rows_raw = (rows_eff == 1 && $urandom_range(0, 1)) ? 9'd0 : CFG_W'(rows_eff);
                cols_raw = (cols_eff == 1 && $urandom_range(0, 1)) ? 9'd0 : CFG_W'(cols_eff);
                blk_pct  = BLOCK_PCT[$urandom_range(0, 3)];
            end
            if (rows_raw != dim_rows_reg || cols_raw != dim_cols_reg) begin
                set_dims(rows_raw, cols_raw);
            end
            n_cells = clamp_dim(rows_raw, DIM_LIMIT) * clamp_dim(cols_raw, COL_HI);
            for (int k = 0; k < n_cells; k++) begin
                send_cell(pick_cost(), $urandom_range(0, 99) < blk_pct, 1'b0, NONE);
            end
        end

        cell_if.valid <= 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
